[rtl/loas_frame_splitter_top_defines.svh]
// assertion macros for the loas frame splitter
`ifndef LOAS_FRAME_SPLITTER_TOP_DEFINES_SVH
`define LOAS_FRAME_SPLITTER_TOP_DEFINES_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define LOAS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every rising clock edge outside reset
`define LOAS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/loas_pkg.sv]
package loas_pkg;

    // sync pair: first byte, then a byte with the top three bits set
    localparam logic [7:0]  SYNC_BYTE = 8'h56;
    localparam logic [2:0]  SYNC_TOP  = 3'b111;
    // frame length field counts bytes after the three header bytes
    localparam logic [13:0] LEN_EXTRA = 14'd3;

    // header positions that carry fields
    localparam logic [13:0] HDR_LEN_HI = 14'd1;
    localparam logic [13:0] HDR_LEN_LO = 14'd2;
    localparam logic [13:0] HDR_CHAN   = 14'd6;

    typedef enum logic [2:0] {
        LOCK_HUNT   = 3'b001,
        LOCK_ON     = 3'b010,
        LOCK_RESYNC = 3'b100
    } lock_state_t;

    typedef enum logic [1:0] {
        KIND_DISCARD = 2'd0,
        KIND_FRAME   = 2'd1,
        KIND_START   = 2'd2,
        KIND_NEW_SEG = 2'd3
    } kind_t;

endpackage

[rtl/loas_frame_splitter_top.sv]
// channel   direction  handshake                  payload
// data      in         data_valid / data_stall    data_byte, end_of_stream
// result    out        result_valid / result_stall out_byte, byte_kind, channel_config,
//                                                 segment_number, sync_lost, last_item
//
// one word per clock unless stalled; each byte comes back one word later, once the
// following byte has given the lookahead needed to recognize the sync pair
// a word with end_of_stream while a byte is held makes two results: the held
// byte goes out at once and the final byte from the flush state, data_stall high then
// the result register frees on the same edge it is taken, so result_stall
// reaches data_stall combinationally and a full pipe keeps moving
// rst_n clears lock, frame counters, channel and segment count (async, low)
`include "loas_frame_splitter_top_defines.svh"

module loas_frame_splitter_top
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        data_valid,
    output logic        data_stall,
    input  logic [7:0]  data_byte,
    input  logic        end_of_stream,

    output logic        result_valid,
    input  logic        result_stall,
    output logic [7:0]  out_byte,
    output logic [1:0]  byte_kind,
    output logic [3:0]  channel_config,
    output logic [15:0] segment_number,
    output logic        sync_lost,
    output logic        last_item
);

    // lock and frame state
    loas_pkg::lock_state_t lock_reg, lock_next;
    logic [13:0] pos_reg, pos_next;
    logic [13:0] flen_reg, flen_next;
    logic [4:0]  hdr1_reg, hdr1_next;
    logic        chan_valid_reg, chan_valid_next;
    logic [3:0]  chan_reg, chan_next;
    logic        cut_reg, cut_next;
    logic [15:0] seg_reg, seg_next;

    // held byte waiting for its lookahead, and the pending final byte
    logic [7:0]  held_byte_reg;
    logic        held_valid_reg;
    logic        flush_reg;

    // result register
    logic        result_valid_reg;
    logic [7:0]  out_byte_reg;
    loas_pkg::kind_t kind_reg, kind_next;
    logic [3:0]  chan_out_reg;
    logic [15:0] seg_out_reg;
    logic        lost_reg, lost_next;
    logic        last_reg;

    // classifier inputs and helpers
    logic        can_emit;
    logic        accept;
    logic        fire;
    logic [7:0]  cls_byte;
    logic        cls_has_next;
    logic [7:0]  cls_look;
    logic        cls_last;
    logic        second_ok;
    logic        pair;
    logic [13:0] pos_inc;
    logic        start;
    logic        new_seg;
    logic        cap_en;
    logic [13:0] cap_pos;

    assign can_emit   = !result_valid_reg || !result_stall;
    assign data_stall = flush_reg || !can_emit;
    assign accept     = data_valid && !data_stall;

    // one classification per cycle at most
    assign fire = can_emit && (flush_reg || (accept && (held_valid_reg || end_of_stream)));

    always_comb
    begin
        // pick what gets classified this cycle
        if (flush_reg)
        begin
            cls_byte     = held_byte_reg;
            cls_has_next = 1'b0;
            cls_look     = 8'd0;
            cls_last     = 1'b1;
        end
        else if (held_valid_reg)
        begin
            cls_byte     = held_byte_reg;
            cls_has_next = 1'b1;
            cls_look     = data_byte;
            cls_last     = 1'b0;
        end
        else
        begin
            // nothing held: only reached with end_of_stream
            cls_byte     = data_byte;
            cls_has_next = 1'b0;
            cls_look     = 8'd0;
            cls_last     = 1'b1;
        end

        // without lookahead, a locked boundary trusts the first sync byte
        second_ok = cls_has_next ? (cls_look[7:5] == loas_pkg::SYNC_TOP)
                                 : (lock_reg == loas_pkg::LOCK_ON);
        pair      = (cls_byte == loas_pkg::SYNC_BYTE) && second_ok;
        pos_inc   = pos_reg + 14'd1;

        lock_next       = lock_reg;
        pos_next        = pos_reg;
        flen_next       = flen_reg;
        hdr1_next       = hdr1_reg;
        chan_valid_next = chan_valid_reg;
        chan_next       = chan_reg;
        cut_next        = cut_reg;
        seg_next        = seg_reg;
        kind_next       = loas_pkg::KIND_DISCARD;
        lost_next       = 1'b0;
        start           = 1'b0;
        new_seg         = 1'b0;
        cap_en          = 1'b0;
        cap_pos         = pos_inc;

        unique case (lock_reg)
            loas_pkg::LOCK_ON:
            begin
                if (pos_inc == flen_reg)
                begin
                    if (pair)
                    begin
                        start = 1'b1;
                    end
                    else
                    begin
                        // expected sync word missing
                        lost_next = 1'b1;
                        kind_next = loas_pkg::KIND_FRAME;
                        lock_next = loas_pkg::LOCK_RESYNC;
                        cut_next  = 1'b1;
                    end
                end
                else
                begin
                    pos_next  = pos_inc;
                    kind_next = loas_pkg::KIND_FRAME;
                    cap_en    = 1'b1;
                end
            end
            loas_pkg::LOCK_RESYNC:
            begin
                if (pair)
                    start = 1'b1;
                else
                    kind_next = loas_pkg::KIND_FRAME;
            end
            default:
            begin
                if (pair)
                    start = 1'b1;
            end
        endcase

        if (start)
        begin
            new_seg   = cut_reg || (lock_reg != loas_pkg::LOCK_ON);
            pos_next  = 14'd0;
            lock_next = loas_pkg::LOCK_ON;
            cut_next  = 1'b0;
            cap_en    = 1'b1;
            cap_pos   = 14'd0;
            if (new_seg)
            begin
                seg_next        = seg_reg + 16'd1;
                chan_valid_next = 1'b0;
                kind_next       = loas_pkg::KIND_NEW_SEG;
            end
            else
            begin
                kind_next = loas_pkg::KIND_START;
            end
        end

        // header field capture; a frame start is always position zero,
        // so the channel check never meets the new-segment path
        if (cap_en)
        begin
            if (cap_pos == loas_pkg::HDR_LEN_HI)
                hdr1_next = cls_byte[4:0];
            if (cap_pos == loas_pkg::HDR_LEN_LO)
                flen_next = {1'b0, hdr1_reg, cls_byte} + loas_pkg::LEN_EXTRA;
            if (cap_pos == loas_pkg::HDR_CHAN)
            begin
                if (!chan_valid_reg)
                begin
                    chan_valid_next = 1'b1;
                    chan_next       = cls_byte[6:3];
                end
                else if (chan_reg != cls_byte[6:3])
                begin
                    // channel change opens a segment on this byte
                    chan_next = cls_byte[6:3];
                    seg_next  = seg_reg + 16'd1;
                    kind_next = loas_pkg::KIND_NEW_SEG;
                end
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lock_reg         <= loas_pkg::LOCK_HUNT;
            pos_reg          <= 14'd0;
            flen_reg         <= 14'd0;
            chan_valid_reg   <= 1'b0;
            chan_reg         <= 4'd0;
            cut_reg          <= 1'b0;
            seg_reg          <= 16'd0;
            held_valid_reg   <= 1'b0;
            flush_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                lock_reg       <= lock_next;
                pos_reg        <= pos_next;
                flen_reg       <= flen_next;
                chan_valid_reg <= chan_valid_next;
                chan_reg       <= chan_next;
                cut_reg        <= cut_next;
                seg_reg        <= seg_next;
            end

            if (flush_reg)
            begin
                if (can_emit)
                    flush_reg <= 1'b0;
            end
            else if (accept)
            begin
                if (end_of_stream)
                begin
                    // a held byte goes out now, the final byte from the flush state
                    flush_reg      <= held_valid_reg;
                    held_valid_reg <= 1'b0;
                end
                else
                begin
                    held_valid_reg <= 1'b1;
                end
            end

            result_valid_reg <= fire || (result_valid_reg && result_stall);
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
            held_byte_reg <= data_byte;
        if (fire)
        begin
            hdr1_reg     <= hdr1_next;
            out_byte_reg <= cls_byte;
            kind_reg     <= kind_next;
            chan_out_reg <= chan_valid_next ? chan_next : 4'd0;
            seg_out_reg  <= seg_next;
            lost_reg     <= lost_next;
            last_reg     <= cls_last;
        end
    end

    assign result_valid   = result_valid_reg;
    assign out_byte       = out_byte_reg;
    assign byte_kind      = kind_reg;
    assign channel_config = chan_out_reg;
    assign segment_number = seg_out_reg;
    assign sync_lost      = lost_reg;
    assign last_item      = last_reg;

    // a lost sync word is still delivered as a frame byte
    `LOAS_ASSERT_NOW(a_lost_is_frame, result_valid && sync_lost, byte_kind == loas_pkg::KIND_FRAME, "sync loss on a byte that is not a frame byte")

    // bytes before first lock see no segment and no channel
    `LOAS_ASSERT_NOW(a_discard_unlocked, result_valid && byte_kind == loas_pkg::KIND_DISCARD, segment_number == 16'd0 && channel_config == 4'd0, "discarded byte after lock")

    // every new-segment result advances the segment count by exactly one
    `LOAS_ASSERT_NEXT(a_seg_step, fire && kind_next == loas_pkg::KIND_NEW_SEG, seg_reg == $past(seg_reg) + 16'd1, "segment count did not step by one")

    // end of stream with a byte held leaves the final byte pending
    `LOAS_ASSERT_NEXT(a_flush_pending, accept && end_of_stream && held_valid_reg, flush_reg && !held_valid_reg, "final byte not pending after end of stream")

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps

// testbench for the loas frame splitter
// a short directed table walks first lock, a channel change, a missed sync and
// both kinds of flush, then a long random stream of mostly well formed frames
// with random content, broken syncs, truncated frames and garbage between them
// every accepted result word is checked against a local predictor of the deframer or a typed-in directed result
module tb;

    // stream constants of the deframer
    localparam logic [4:0] NO_CHAN = 5'h10;
    localparam int N_DIR   = 25;
    localparam int N_RAND  = 1750;
    localparam int DRAIN   = 20;
    localparam int MAX_MSG = 10;

    // one result word as the block gives it
    typedef struct packed {
        logic [7:0]  out_byte;
        logic [1:0]  kind;
        logic [3:0]  chan;
        logic [15:0] seg;
        logic        lost;
        logic        last;
    } frame_out_t;

    // one directed row: the input word and, where fixed, the result it must cause
    typedef struct packed {
        logic [7:0] data;
        logic       eos;
        logic       fixed;
        frame_out_t want;
    } dir_row_t;

    // flushes right after reset, first lock, a second frame with a channel change,
    // a missed sync, a resync on a real pair and a flush with a byte held
    localparam dir_row_t DIR_TAB [N_DIR] = '{
        // flush right after reset, nothing held, extremes of the byte
        '{8'h00, 1'b1, 1'b1, '{8'h00, loas_pkg::KIND_DISCARD, 4'd0, 16'd0, 1'b0, 1'b1}},
        '{8'hFF, 1'b1, 1'b1, '{8'hFF, loas_pkg::KIND_DISCARD, 4'd0, 16'd0, 1'b0, 1'b1}},
        // first frame, length 8, channel 1
        '{8'h56, 1'b0, 1'b0, '0},
        '{8'hE0, 1'b0, 1'b1, '{8'h56, loas_pkg::KIND_NEW_SEG, 4'd0, 16'd1, 1'b0, 1'b0}},
        '{8'h05, 1'b0, 1'b0, '0},
        '{8'h11, 1'b0, 1'b0, '0},
        '{8'h22, 1'b0, 1'b0, '0},
        '{8'h33, 1'b0, 1'b0, '0},
        '{8'h08, 1'b0, 1'b0, '0},
        '{8'h44, 1'b0, 1'b0, '0},
        // second frame, channel moves to 15 on header byte 6
        '{8'h56, 1'b0, 1'b0, '0},
        '{8'hE0, 1'b0, 1'b0, '0},
        '{8'h05, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hAA, 1'b0, 1'b0, '0},
        '{8'h78, 1'b0, 1'b0, '0},
        '{8'h55, 1'b0, 1'b0, '0},
        // sync word missing where the third frame should start
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h56, 1'b0, 1'b1, '{8'h00, loas_pkg::KIND_FRAME, 4'd15, 16'd2, 1'b1, 1'b0}},
        // 0x12 while resyncing, then 0x56 with 0xFF as a valid second byte
        '{8'h12, 1'b0, 1'b0, '0},
        '{8'h56, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        // flush with a byte held, two results
        '{8'h56, 1'b1, 1'b0, '0}
    };

    logic        clk = 1'b1;
    logic        rst_n;
    logic        data_valid;
    logic        data_stall;
    logic [7:0]  data_byte;
    logic        end_of_stream;
    logic        result_valid;
    logic        result_stall;
    logic [7:0]  out_byte;
    logic [1:0]  byte_kind;
    logic [3:0]  channel_config;
    logic [15:0] segment_number;
    logic        sync_lost;
    logic        last_item;

    // stimulus stream and the results still owed by the block
    logic [7:0]  stream_bytes [$];
    logic        stream_eos [$];
    frame_out_t  pending_bytes [$];
    int          errors = 0;

    // deframer state of the predictor
    loas_pkg::lock_state_t lk_mode;
    logic [13:0] frm_pos;
    logic [13:0] frm_len;
    logic [7:0]  held_data;
    logic        held_ok;
    logic [7:0]  hdr [7];
    logic [4:0]  cur_chan;
    logic        cut_next;
    logic [15:0] seg_cnt;

    loas_frame_splitter_top i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .data_valid     (data_valid),
        .data_stall     (data_stall),
        .data_byte      (data_byte),
        .end_of_stream  (end_of_stream),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .out_byte       (out_byte),
        .byte_kind      (byte_kind),
        .channel_config (channel_config),
        .segment_number (segment_number),
        .sync_lost      (sync_lost),
        .last_item      (last_item)
    );

    // 4 ns clock
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // store header bytes; length after byte 2, channel change on byte 6
    task automatic take_header(input logic [7:0] h, inout logic [1:0] k);
        logic [4:0] ch;
        if (frm_pos < 14'd7)
        begin
            hdr[frm_pos[2:0]] = h;
            if (frm_pos == loas_pkg::HDR_LEN_LO)
                frm_len = {1'b0, hdr[loas_pkg::HDR_LEN_HI[2:0]][4:0], h}
                          + loas_pkg::LEN_EXTRA;
            if (frm_pos == loas_pkg::HDR_CHAN)
            begin
                ch = {1'b0, h[6:3]};
                if (cur_chan == NO_CHAN)
                    cur_chan = ch;
                else if (cur_chan != ch)
                begin
                    cur_chan = ch;
                    seg_cnt  = seg_cnt + 16'd1;
                    k        = loas_pkg::KIND_NEW_SEG;
                end
            end
        end
    endtask

    // classify one byte, given the following byte where there is one
    task automatic deframe_byte(input logic [7:0] h, input logic has_next,
                                input logic [7:0] n, input logic last,
                                output frame_out_t res);
        logic [1:0]  k;
        logic        lost;
        logic        sec_ok;
        logic        pair;
        logic        start;
        logic        newseg;
        logic [13:0] nxt;
        k      = loas_pkg::KIND_DISCARD;
        lost   = 1'b0;
        start  = 1'b0;
        sec_ok = has_next ? (n[7:5] == loas_pkg::SYNC_TOP) : (lk_mode == loas_pkg::LOCK_ON);
        pair   = (h == loas_pkg::SYNC_BYTE) && sec_ok;
        if (lk_mode == loas_pkg::LOCK_ON)
        begin
            nxt = frm_pos + 14'd1;
            if (nxt == frm_len)
            begin
                if (pair)
                    start = 1'b1;
                else
                begin
                    // expected sync word is missing
                    lost     = 1'b1;
                    k        = loas_pkg::KIND_FRAME;
                    lk_mode  = loas_pkg::LOCK_RESYNC;
                    cut_next = 1'b1;
                end
            end
            else
            begin
                frm_pos = nxt;
                k       = loas_pkg::KIND_FRAME;
                take_header(h, k);
            end
        end
        else if (pair)
            start = 1'b1;
        else
            k = (lk_mode == loas_pkg::LOCK_RESYNC) ? loas_pkg::KIND_FRAME
                                                   : loas_pkg::KIND_DISCARD;
        if (start)
        begin
            newseg   = cut_next || (lk_mode != loas_pkg::LOCK_ON);
            frm_pos  = 14'd0;
            lk_mode  = loas_pkg::LOCK_ON;
            cut_next = 1'b0;
            if (newseg)
            begin
                seg_cnt  = seg_cnt + 16'd1;
                cur_chan = NO_CHAN;
                k        = loas_pkg::KIND_NEW_SEG;
            end
            else
                k = loas_pkg::KIND_START;
            take_header(h, k);
        end
        res.out_byte = h;
        res.kind     = k;
        res.chan     = (cur_chan == NO_CHAN) ? 4'd0 : cur_chan[3:0];
        res.seg      = seg_cnt;
        res.lost     = lost;
        res.last     = last;
    endtask

    // one accepted input word: release the held byte, flush on end of stream
    task automatic feed_word(input logic [7:0] b, input logic eos);
        frame_out_t res;
        if (held_ok)
        begin
            deframe_byte(held_data, 1'b1, b, 1'b0, res);
            pending_bytes.push_back(res);
        end
        if (eos)
        begin
            deframe_byte(b, 1'b0, 8'h00, 1'b1, res);
            pending_bytes.push_back(res);
            held_ok   = 1'b0;
            held_data = 8'h00;
        end
        else
        begin
            held_data = b;
            held_ok   = 1'b1;
        end
    endtask

    task automatic add_word(input logic [7:0] b, input logic eos);
        stream_bytes.push_back(b);
        stream_eos.push_back(eos);
    endtask

    // random stream: mostly frames, some broken, garbage and flushes between
    task automatic make_random_stream();
        int          r;
        int          flen;
        int          nemit;
        logic [4:0]  hi;
        logic [7:0]  lo;
        logic [7:0]  b;
        logic [3:0]  ch;
        logic        bad_sync;
        logic        bad_top;
        ch = 4'($urandom_range(15));
        while (stream_bytes.size() < N_DIR + N_RAND)
        begin
            r = $urandom_range(99);
            if (r < 8)
            begin
                // garbage burst, rich in sync bytes
                repeat ($urandom_range(1, 6))
                    add_word(($urandom_range(2) == 0) ? loas_pkg::SYNC_BYTE
                                                      : 8'($urandom_range(255)),
                             $urandom_range(99) == 0);
            end
            else if (r < 13)
            begin
                // flush at a frame boundary: a sync byte or anything else
                add_word(($urandom_range(1) == 0) ? loas_pkg::SYNC_BYTE
                                                  : 8'($urandom_range(255)),
                         1'b1);
            end
            else
            begin
                if ($urandom_range(29) == 0)
                begin
                    hi = 5'd1;
                    lo = 8'($urandom_range(255));
                end
                else
                begin
                    hi = 5'd0;
                    lo = 8'($urandom_range(40));
                end
                flen = hi * 256 + lo + 3;
                nemit = ($urandom_range(19) == 0) ? $urandom_range(1, flen - 1) : flen;
                bad_sync = ($urandom_range(24) == 0);
                bad_top  = ($urandom_range(24) == 0);
                if ($urandom_range(4) == 0)
                    ch = 4'($urandom_range(15));
                for (int p = 0; p < nemit; p++)
                begin
                    case (p)
                        0: b = bad_sync ? 8'($urandom_range(255)) : loas_pkg::SYNC_BYTE;
                        1: b = bad_top ? {3'($urandom_range(6)), hi}
                                       : {loas_pkg::SYNC_TOP, hi};
                        2: b = lo;
                        6: b = {1'($urandom_range(1)), ch, 3'($urandom_range(7))};
                        default: b = 8'($urandom_range(255));
                    endcase
                    add_word(b, $urandom_range(199) == 0);
                end
            end
        end
    endtask

    // compare one result word with the oldest expectation
    task automatic check_word(input frame_out_t got);
        frame_out_t want;
        logic       bad;
        if (pending_bytes.size() == 0)
        begin
            errors++;
            if (errors <= MAX_MSG)
                $display("unexpected result: byte %h kind %0d chan %0d seg %0d lost %b last %b",
                         got.out_byte, got.kind, got.chan, got.seg, got.lost, got.last);
        end
        else
        begin
            want = pending_bytes.pop_front();
            bad = (got.out_byte !== want.out_byte) || (got.kind !== want.kind) ||
                  (got.chan !== want.chan) || (got.seg !== want.seg) ||
                  (got.lost !== want.lost) || (got.last !== want.last);
            if (bad)
            begin
                errors++;
                if (errors <= MAX_MSG)
                begin
                    $display("mismatch exp: byte %h kind %0d chan %0d seg %0d lost %b last %b",
                             want.out_byte, want.kind, want.chan, want.seg, want.lost, want.last);
                    $display("         got: byte %h kind %0d chan %0d seg %0d lost %b last %b",
                             got.out_byte, got.kind, got.chan, got.seg, got.lost, got.last);
                end
            end
        end
    endtask

    // idle phases: receiver stalls most, then sender idles most, then neither
    function automatic int send_idle_pct(input int i, input int n);
        case (i * 3 / n)
            0: return 27;
            1: return 68;
            default: return 0;
        endcase
    endfunction

    function automatic int recv_stall_pct(input int i, input int n);
        case (i * 3 / n)
            0: return 68;
            1: return 27;
            default: return 0;
        endcase
    endfunction

    // main driver and monitor
    // handshakes are sampled at the falling edge, where every signal is settled
    // for the coming rising edge, and acted on at that rising edge
    initial
    begin
        int         idx;
        int         n_items;
        int         settle;
        logic       in_take;
        logic       out_take;
        frame_out_t seen;

        // the directed table comes first in the stream
        for (int i = 0; i < N_DIR; i++)
            add_word(DIR_TAB[i].data, DIR_TAB[i].eos);
        make_random_stream();
        n_items = stream_bytes.size();

        // predictor starts from the reset state
        lk_mode   = loas_pkg::LOCK_HUNT;
        frm_pos   = '0;
        frm_len   = '0;
        held_data = '0;
        held_ok   = 1'b0;
        for (int i = 0; i < 7; i++)
            hdr[i] = '0;
        cur_chan  = NO_CHAN;
        cut_next  = 1'b0;
        seg_cnt   = '0;

        rst_n         = 1'b0;
        data_valid    = 1'b0;
        data_byte     = 8'h00;
        end_of_stream = 1'b0;
        result_stall  = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        idx    = 0;
        settle = 0;
        while (settle < DRAIN)
        begin
            @(negedge clk);
            in_take  = data_valid && !data_stall;
            out_take = result_valid && !result_stall;
            seen     = '{out_byte, byte_kind, channel_config, segment_number,
                         sync_lost, last_item};
            @(posedge clk);

            // accepted input word: predict what it causes
            if (in_take)
            begin
                feed_word(stream_bytes[idx], stream_eos[idx]);
                // directed rows with a result typed in replace the prediction
                if (idx < N_DIR && DIR_TAB[idx].fixed)
                begin
                    void'(pending_bytes.pop_back());
                    pending_bytes.push_back(DIR_TAB[idx].want);
                end
                idx++;
            end
            if (out_take)
                check_word(seen);

            // next word, or idle; a stalled word holds
            if (!data_valid || in_take)
            begin
                if (idx < n_items && $urandom_range(99) >= send_idle_pct(idx, n_items))
                begin
                    data_valid    <= 1'b1;
                    data_byte     <= stream_bytes[idx];
                    end_of_stream <= stream_eos[idx];
                end
                else
                    data_valid <= 1'b0;
            end
            result_stall <= ($urandom_range(99) < recv_stall_pct(idx, n_items));

            // after the last word, wait for every result to be checked, then for the drain period
            if (idx == n_items && pending_bytes.size() == 0)
                settle++;
            else
                settle = 0;
        end

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
